### sv/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants for the radix digit emitter
// Holds the controller states, the command and status structs that join the
// controller to the datapath, and the fixed character and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // The alphabet holds at most 16 characters, so a digit fits in 4 bits.
    localparam int DIGIT_W    = 4;
    localparam int ALPHA_SIZE = 16;
    localparam int COUNT_W    = 5;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_DIGIT_COUNT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic step_last;
        logic idx_zero;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/rde_regs.sv
// ----------------------------------------------------------------------------
// rde_regs: configuration register file
// Three registers on a 64-bit APB-style port at byte addresses 0, 8 and 16.
// Writes complete in the access cycle; reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rde_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [rde_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready,
    output logic      [rde_pkg::COUNT_W-1:0]         digit_count,
    output logic      [rde_pkg::CFG_DATA_W-1:0]      alphabet_low,
    output logic      [rde_pkg::CFG_DATA_W-1:0]      alphabet_high
);

    logic [rde_pkg::COUNT_W-1:0]    count_reg;
    logic [rde_pkg::CFG_DATA_W-1:0] alpha_low_reg;
    logic [rde_pkg::CFG_DATA_W-1:0] alpha_high_reg;
    logic [rde_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rde_pkg::CFG_ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rde_pkg::REG_DIGIT_COUNT:
                    count_reg <= pwdata[rde_pkg::COUNT_W-1:0];
                rde_pkg::REG_ALPHABET_LOW:
                    alpha_low_reg <= pwdata;
                rde_pkg::REG_ALPHABET_HIGH:
                    alpha_high_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rde_pkg::REG_DIGIT_COUNT:
                prdata = {{(rde_pkg::CFG_DATA_W-rde_pkg::COUNT_W){1'b0}}, count_reg};
            rde_pkg::REG_ALPHABET_LOW:
                prdata = alpha_low_reg;
            rde_pkg::REG_ALPHABET_HIGH:
                prdata = alpha_high_reg;
            default:
                prdata = '0;
        endcase
    end

    assign digit_count   = count_reg;
    assign alphabet_low  = alpha_low_reg;
    assign alphabet_high = alpha_high_reg;

endmodule

`default_nettype wire

### sv/rde_ctrl.sv
// ----------------------------------------------------------------------------
// rde_ctrl: sequencing state machine
// Steps the datapath through load, bit-serial radix conversion, the optional
// sign character and the digit characters, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire rde_pkg::dp_status_t status,
    output logic                     busy,
    output rde_pkg::dp_cmd_t         cmd
);

    rde_pkg::ctrl_state_t state_reg;
    rde_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rde_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rde_pkg::ST_IDLE:
            begin
                // An invalid alphabet still takes the transaction but emits nothing.
                if (start && status.alpha_ok)
                    state_next = rde_pkg::ST_CONVERT;
            end
            rde_pkg::ST_CONVERT:
            begin
                if (status.step_last)
                    state_next = status.neg ? rde_pkg::ST_SIGN : rde_pkg::ST_EMIT;
            end
            rde_pkg::ST_SIGN:
                state_next = rde_pkg::ST_EMIT;
            rde_pkg::ST_EMIT:
            begin
                if (status.idx_zero)
                    state_next = rde_pkg::ST_IDLE;
            end
            default:
                state_next = rde_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            rde_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            rde_pkg::ST_CONVERT:
                cmd.step = 1'b1;
            rde_pkg::ST_SIGN:
                cmd.emit_sign = 1'b1;
            rde_pkg::ST_EMIT:
                cmd.emit_digit = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

### sv/rde_dp.sv
// ----------------------------------------------------------------------------
// rde_dp: conversion and emission datapath
// Shifts the magnitude in one bit per cycle, MSB first, into a row of radix
// digit cells (each cell doubles and adds the carry from below, reducing by
// the radix), then reads the cells back out through the alphabet.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_dp #(
    parameter int VALUE_BITS   = 32,
    parameter int MAX_ALPHABET = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire rde_pkg::dp_cmd_t                    cmd,
    input  wire logic [VALUE_BITS-1:0]               value,
    input  wire logic [rde_pkg::COUNT_W-1:0]         digit_count,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0]      alphabet_low,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0]      alphabet_high,
    output rde_pkg::dp_status_t                      status,
    output logic      [7:0]                          char_out,
    output logic                                     last,
    output logic                                     strobe
);

    localparam int IDX_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DW    = rde_pkg::DIGIT_W;

    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [DW-1:0]         digit_reg [VALUE_BITS];
    logic [CNT_W-1:0]      total_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      step_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;
    logic                  strobe_reg;

    logic [7:0]            alpha_chars [rde_pkg::ALPHA_SIZE];
    logic                  alpha_ok;
    logic [VALUE_BITS-1:0] gen_vec;
    logic [VALUE_BITS-1:0] prop_vec;
    logic [VALUE_BITS:0]   carry_sum;
    logic [VALUE_BITS:0]   carry_vec;
    logic [DW:0]           cell_next [VALUE_BITS];
    logic                  grow;
    logic [DW-1:0]         sel_digit;

    // Alphabet check: count in range, no sign characters, no repeats.
    always_comb
    begin
        for (int i = 0; i < rde_pkg::ALPHA_SIZE; i++)
        begin
            if (i < 8)
                alpha_chars[i] = alphabet_low[8*i +: 8];
            else
                alpha_chars[i] = alphabet_high[8*(i-8) +: 8];
        end
        alpha_ok = (digit_count >= rde_pkg::COUNT_W'(2)) &&
                   (digit_count <= rde_pkg::COUNT_W'(MAX_ALPHABET));
        for (int i = 0; i < rde_pkg::ALPHA_SIZE; i++)
        begin
            if (rde_pkg::COUNT_W'(i) < digit_count)
            begin
                if (alpha_chars[i] == rde_pkg::CHAR_PLUS ||
                    alpha_chars[i] == rde_pkg::CHAR_MINUS)
                    alpha_ok = 1'b0;
                for (int j = i + 1; j < rde_pkg::ALPHA_SIZE; j++)
                begin
                    if (rde_pkg::COUNT_W'(j) < digit_count &&
                        alpha_chars[j] == alpha_chars[i])
                        alpha_ok = 1'b0;
                end
            end
        end
    end

    // A cell carries out when 2d >= radix (generate) or when 2d + 1 equals
    // the radix and a carry comes in (propagate). The two never overlap, so
    // the whole carry row falls out of one add.
    always_comb
    begin
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            gen_vec[i]  = {1'b0, digit_reg[i], 1'b0} >= {1'b0, digit_count};
            prop_vec[i] = {1'b0, digit_reg[i], 1'b1} == {1'b0, digit_count};
        end
        carry_sum = {1'b0, gen_vec | prop_vec} + {1'b0, gen_vec}
                  + {{VALUE_BITS{1'b0}}, mag_reg[VALUE_BITS-1]};
        carry_vec = carry_sum ^ {1'b0, gen_vec | prop_vec} ^ {1'b0, gen_vec};
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            cell_next[i] = {digit_reg[i], carry_vec[i]};
            if (carry_vec[i+1])
                cell_next[i] = cell_next[i] - digit_count;
        end
    end

    // A carry into the cell just above the top digit adds one digit.
    assign grow      = carry_vec[total_reg];
    assign sel_digit = digit_reg[idx_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // The most negative value negates to itself, which reads as 2^(n-1).
            mag_reg  <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            neg_reg  <= value[VALUE_BITS-1];
            step_reg <= IDX_W'(VALUE_BITS - 1);
            for (int i = 0; i < VALUE_BITS; i++)
                digit_reg[i] <= '0;
        end
        else if (cmd.step)
        begin
            mag_reg  <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            step_reg <= step_reg - IDX_W'(1);
            for (int i = 0; i < VALUE_BITS; i++)
                digit_reg[i] <= cell_next[i][DW-1:0];
        end
        if (cmd.emit_sign)
        begin
            char_reg <= rde_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= alpha_chars[sel_digit];
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign | cmd.emit_digit;
            if (cmd.load)
            begin
                total_reg <= CNT_W'(1);
                idx_reg   <= '0;
            end
            else if (cmd.step)
            begin
                if (grow)
                begin
                    total_reg <= total_reg + CNT_W'(1);
                    idx_reg   <= idx_reg + IDX_W'(1);
                end
            end
            else if (cmd.emit_digit)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    assign status.alpha_ok  = alpha_ok;
    assign status.neg       = neg_reg;
    assign status.step_last = (step_reg == '0);
    assign status.idx_zero  = (idx_reg == '0);

    assign char_out = char_reg;
    assign last     = last_reg;
    assign strobe   = strobe_reg;

endmodule

`default_nettype wire

### sv/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter: signed integer to text in a configurable radix
// Numbers are taken one at a time: start is accepted only while busy is low,
// after the sequencer has issued the last character of the previous number.
// Conversion is bit-serial; the characters then stream one per cycle, and the
// receiver cannot stall them.
// Reset (rst_n low) clears the configuration registers, the sequencer and the
// strobe; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter #(
    parameter int VALUE_BITS   = 32,
    parameter int MAX_ALPHABET = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [VALUE_BITS-1:0]        value,
    output logic      [7:0]                          char_out,
    output logic                                     last,
    output logic                                     strobe,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rde_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [rde_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready
);

    logic [rde_pkg::COUNT_W-1:0]    digit_count;
    logic [rde_pkg::CFG_DATA_W-1:0] alphabet_low;
    logic [rde_pkg::CFG_DATA_W-1:0] alphabet_high;
    rde_pkg::dp_cmd_t               cmd;
    rde_pkg::dp_status_t            status;

    rde_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .digit_count   (digit_count),
        .alphabet_low  (alphabet_low),
        .alphabet_high (alphabet_high)
    );

    rde_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    rde_dp #(
        .VALUE_BITS   (VALUE_BITS),
        .MAX_ALPHABET (MAX_ALPHABET)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (value),
        .digit_count   (digit_count),
        .alphabet_low  (alphabet_low),
        .alphabet_high (alphabet_high),
        .status        (status),
        .char_out      (char_out),
        .last          (last),
        .strobe        (strobe)
    );

endmodule

`default_nettype wire

### test/tb_radix_digit_emitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter: self-checking testbench for the radix digit emitter
// Writes the radix and the alphabet over the register port and sends signed
// numbers with random gaps. A scoreboard computes the expected character
// stream of each accepted number and checks every strobed character in order.
// ----------------------------------------------------------------------------

module tb_radix_digit_emitter;

    localparam int  VALUE_W     = 32;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  SETTLE      = 70;   // longer than the slowest number takes
    localparam int  RANDOM_ITEMS = 330;

    // Keeps the register copy and the queue of characters still to come.
    class radix_scoreboard;
        logic [rde_pkg::COUNT_W-1:0] radix;
        logic [127:0]       alphabet;
        logic [7:0]         pending_char[$];
        logic               pending_last[$];
        int                 errors;
        int                 numbers_rendered;
        int                 numbers_dropped;
        int                 chars_checked;

        function new();
            radix = '0;
            alphabet = '0;
            errors = 0;
            numbers_rendered = 0;
            numbers_dropped = 0;
            chars_checked = 0;
        endfunction

        function void set_register(logic [rde_pkg::REG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == rde_pkg::REG_DIGIT_COUNT)
                radix = data[rde_pkg::COUNT_W-1:0];
            else if (idx == rde_pkg::REG_ALPHABET_LOW)
                alphabet[63:0] = data;
            else if (idx == rde_pkg::REG_ALPHABET_HIGH)
                alphabet[127:64] = data;
        endfunction

        function bit alphabet_valid();
            int n;
            n = int'(radix);
            if (n < 2 || n > rde_pkg::ALPHA_SIZE)
                return 0;
            for (int i = 0; i < n; i++)
            begin
                if (alphabet[i*8 +: 8] == rde_pkg::CHAR_PLUS ||
                    alphabet[i*8 +: 8] == rde_pkg::CHAR_MINUS)
                    return 0;
                for (int j = i + 1; j < n; j++)
                    if (alphabet[j*8 +: 8] == alphabet[i*8 +: 8])
                        return 0;
            end
            return 1;
        endfunction

        // Renders one accepted number into its expected characters.
        function void note_value(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digits[0:VALUE_W-1];
            int                 n;
            if (!alphabet_valid())
            begin
                numbers_dropped++;
                return;
            end
            // Two's complement negation also gives 2^31 for the most negative value.
            mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
            n = 0;
            do
            begin
                digits[n] = 4'(mag % VALUE_W'(radix));
                n++;
                mag = mag / VALUE_W'(radix);
            end
            while (mag != 0);
            if (v[VALUE_W-1])
            begin
                pending_char.push_back(rde_pkg::CHAR_MINUS);
                pending_last.push_back(1'b0);
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                pending_char.push_back(alphabet[digits[k]*8 +: 8]);
                pending_last.push_back(k == 0);
            end
            numbers_rendered++;
        endfunction

        function void check_char(logic [7:0] c, logic l);
            logic [7:0] want_char;
            logic       want_last;
            chars_checked++;
            if (pending_char.size() == 0)
            begin
                $display("%0t: unexpected character %h (last %b) with nothing expected",
                         $time, c, l);
                errors++;
                return;
            end
            want_char = pending_char.pop_front();
            want_last = pending_last.pop_front();
            if (c !== want_char)
            begin
                $display("%0t: char_out mismatch, expected %h, actual %h",
                         $time, want_char, c);
                errors++;
            end
            if (l !== want_last)
            begin
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, want_last, l);
                errors++;
            end
        endfunction

        function int pending();
            return pending_char.size();
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic signed [VALUE_W-1:0]    value;
    logic [7:0]                   char_out;
    logic                         last;
    logic                         strobe;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [rde_pkg::CFG_ADDR_W-1:0] paddr;
    logic [rde_pkg::CFG_DATA_W-1:0] pwdata;
    logic [rde_pkg::CFG_DATA_W-1:0] prdata;
    logic                         pready;

    radix_scoreboard              sb;
    int                           cycle_count = 0;
    int                           settings_applied;

    radix_digit_emitter #(
        .VALUE_BITS   (VALUE_W),
        .MAX_ALPHABET (rde_pkg::ALPHA_SIZE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .char_out (char_out),
        .last     (last),
        .strobe   (strobe),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe === 1'b1)
            sb.check_char(char_out, last);
    end

    // Holds start high until the block takes the number.
    task automatic send_value(logic [VALUE_W-1:0] v);
        @(negedge clk);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_value(v);
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Random gap before the next transaction; long gaps now and then.
    task automatic maybe_idle(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 70));
            else
                hold_off($urandom_range(1, 4));
        end
    endtask

    task automatic wait_drained();
        hold_off(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [rde_pkg::REG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // An ignored number leaves no result behind, so wait out busy and a margin.
    task automatic apply_setting(logic [63:0] count_word, logic [127:0] alpha);
        wait_drained();
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(rde_pkg::REG_DIGIT_COUNT, count_word);
        write_reg(rde_pkg::REG_ALPHABET_LOW, alpha[63:0]);
        write_reg(rde_pkg::REG_ALPHABET_HIGH, alpha[127:64]);
        settings_applied++;
    endtask

    // The first count characters are distinct and never a sign; the rest is noise.
    function automatic logic [127:0] random_alphabet(int count);
        logic [127:0] a;
        bit           used[0:255];
        logic [7:0]   c;
        foreach (used[i])
            used[i] = 0;
        for (int i = 0; i < rde_pkg::ALPHA_SIZE; i++)
            a[i*8 +: 8] = 8'($urandom_range(0, 255));
        for (int i = 0; i < count; i++)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (used[c] || c == rde_pkg::CHAR_PLUS || c == rde_pkg::CHAR_MINUS);
            used[c] = 1;
            a[i*8 +: 8] = c;
        end
        return a;
    endfunction

    function automatic logic [127:0] break_alphabet(logic [127:0] a, int count);
        logic [127:0] b;
        int           pos;
        b = a;
        pos = $urandom_range(0, count - 1);
        case ($urandom_range(0, 2))
            0: b[pos*8 +: 8] = rde_pkg::CHAR_PLUS;
            1: b[pos*8 +: 8] = rde_pkg::CHAR_MINUS;
            default: b[pos*8 +: 8] = a[((pos + 1) % count)*8 +: 8];
        endcase
        return b;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = VALUE_W'($urandom_range(0, 40));
            1: v = -VALUE_W'($urandom_range(1, 40));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [127:0] decimal_alpha;
        logic [127:0] byte_alpha;
        logic [127:0] alpha;
        int           valid_sent;
        int           block_len;
        int           idle_pct;
        int           count;
        bit           good;
        bit           paused;

        sb = new();
        settings_applied = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        value   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        decimal_alpha = {48'h0, 64'h3938_3736_3534_3332, 16'h3130} << 0;
        decimal_alpha = 128'h0;
        for (int i = 0; i < 10; i++)
            decimal_alpha[i*8 +: 8] = 8'h30 + 8'(i);
        byte_alpha = {64'hFF0E_0D0C_0B0A_0908, 64'h0706_0504_0302_0100};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Right after reset the radix is zero, so this number is dropped.
        send_value(32'd5);

        apply_setting(64'd10, decimal_alpha);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(-32'sd10);
        send_value(32'd9);

        // Binary gives the longest strings: a sign and 32 digits.
        apply_setting(64'd2, decimal_alpha);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);

        // Sixteen characters including zero and all-ones bytes; the upper
        // bits of the count word must be dropped.
        apply_setting(64'hFFFF_FFFF_FFFF_FFF0, byte_alpha);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        send_value(32'h0123_ABCD);

        apply_setting(64'd17, byte_alpha);
        send_value(32'd1);
        apply_setting(64'd31, byte_alpha);
        send_value(32'd1);
        apply_setting(64'd1, decimal_alpha);
        send_value(32'd1);

        alpha = decimal_alpha;
        alpha[3*8 +: 8] = rde_pkg::CHAR_PLUS;
        apply_setting(64'd10, alpha);
        send_value(32'd1);
        alpha[3*8 +: 8] = rde_pkg::CHAR_MINUS;
        apply_setting(64'd10, alpha);
        send_value(32'd1);
        alpha[3*8 +: 8] = 8'h37;
        apply_setting(64'd10, alpha);
        send_value(32'd1);

        // A repeat that lies past the radix does not spoil the alphabet.
        apply_setting(64'd3, {96'h0, 32'h61_63_62_61});
        send_value(-32'sd7);
        send_value(32'd8);

        valid_sent = 0;
        paused = 0;
        while (valid_sent < RANDOM_ITEMS)
        begin
            good = ($urandom_range(0, 5) != 0);
            if (good)
            begin
                case ($urandom_range(0, 3))
                    0: count = 2;
                    1: count = rde_pkg::ALPHA_SIZE;
                    default: count = $urandom_range(2, rde_pkg::ALPHA_SIZE);
                endcase
                apply_setting(64'(count), random_alphabet(count));
                block_len = $urandom_range(15, 40);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: count = $urandom_range(0, 1);
                    1: count = $urandom_range(rde_pkg::ALPHA_SIZE + 1, 31);
                    default: count = $urandom_range(2, rde_pkg::ALPHA_SIZE);
                endcase
                alpha = random_alphabet(count);
                if (count >= 2 && count <= rde_pkg::ALPHA_SIZE)
                    alpha = break_alphabet(alpha, count);
                apply_setting(64'(count), alpha);
                block_len = 3;
            end

            for (int i = 0; i < block_len; i++)
            begin
                if (valid_sent < RANDOM_ITEMS / 3)
                    idle_pct = 36;
                else if (valid_sent < 2 * RANDOM_ITEMS / 3)
                    idle_pct = 52;
                else
                    idle_pct = 0;
                // Let everything drain once a third of the way in, and now and then at random.
                if ((!paused && valid_sent >= RANDOM_ITEMS / 3) ||
                    $urandom_range(0, 24) == 0)
                begin
                    wait_drained();
                    paused = 1;
                end
                maybe_idle(idle_pct);
                send_value(random_value());
                if (good)
                    valid_sent++;
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Rendered %0d numbers and checked %0d characters under %0d settings.",
                 sb.numbers_rendered, sb.chars_checked, settings_applied);
        $display("%0d numbers were sent while the alphabet was invalid.",
                 sb.numbers_dropped);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
sv/rde_pkg.sv
sv/rde_regs.sv
sv/rde_ctrl.sv
sv/rde_dp.sv
sv/radix_digit_emitter.sv
test/tb_radix_digit_emitter.sv
